/* src/ivde_pkg.sv */
`timescale 1ns / 1ps

package ivde_pkg;

	// Four analog axes, then the button word, in stream order.
	localparam int NUM_AXES        = 4;
	localparam int NUM_LANES       = NUM_AXES + 1;
	localparam int BUTTON_LANE     = NUM_AXES;
	localparam int LANE_IDX_W      = $clog2(NUM_LANES);
	localparam int AXIS_W          = 16;
	localparam int BUTTON_W        = 32;
	localparam int LANE_W          = 32;
	localparam int GROUP_BITS      = 7;
	localparam int MAX_GROUPS      = (LANE_W + GROUP_BITS - 1) / GROUP_BITS;
	localparam int LEN_W           = $clog2(MAX_GROUPS + 1);
	localparam int BYTE_W          = 8;
	localparam int PLAYER_W        = 3;
	localparam int PLAYERS_DEFAULT = 8;

	// Encoded values and their varint byte counts for one item. A count of
	// zero means the lane did not change and sends nothing.
	typedef struct packed {
		logic [NUM_LANES-1:0][LANE_W-1:0] code;
		logic [NUM_LANES-1:0][LEN_W-1:0]  len;
	} ivde_item_t;

	// Number of LEB128 bytes needed for a value, zero for a zero value.
	function automatic logic [LEN_W-1:0] varint_len(input logic [LANE_W-1:0] value);
		logic [LEN_W-1:0] n;
		n = '0;
		for (int g = 0; g < MAX_GROUPS; g++) begin
			if ((value >> (g * GROUP_BITS)) != '0) begin
				n = LEN_W'(g + 1);
			end
		end
		return n;
	endfunction

endpackage

/* src/ivde_axis_lane.sv */
`timescale 1ns / 1ps

module ivde_axis_lane
	import ivde_pkg::*;
(
	input  logic signed [AXIS_W-1:0] old_value,
	input  logic signed [AXIS_W-1:0] new_value,
	output logic        [LANE_W-1:0] code,
	output logic        [LEN_W-1:0]  len
);

	logic signed [AXIS_W:0] diff;
	logic        [AXIS_W:0] zigzag;

	// The difference needs one extra bit; the zigzag form of it still fits
	// in that width because its magnitude is at most twice the axis range.
	assign diff   = {new_value[AXIS_W-1], new_value} - {old_value[AXIS_W-1], old_value};
	assign zigzag = {diff[AXIS_W-1:0], 1'b0} ^ {(AXIS_W + 1){diff[AXIS_W]}};
	assign code   = LANE_W'(zigzag);
	assign len    = varint_len(code);

endmodule

/* src/ivde_serializer.sv */
`timescale 1ns / 1ps

module ivde_serializer
	import ivde_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  ivde_item_t        item,
	output logic              item_take,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] out_byte,
	output logic              last
);

	localparam int PAD_W = MAX_GROUPS * GROUP_BITS;

	ivde_item_t             item_q;
	logic                   busy_q;
	logic                   mask_phase_q;
	logic [LANE_IDX_W-1:0]  lane_q;
	logic [LEN_W-1:0]       byte_q;
	logic                   out_valid_q;
	logic [BYTE_W-1:0]      out_byte_q;
	logic                   last_q;

	logic [NUM_LANES-1:0]   lane_mask;
	logic [NUM_LANES-1:0]   cand;
	logic                   has_next;
	logic [LANE_IDX_W-1:0]  next_lane;
	logic [PAD_W-1:0]       padded;
	logic [GROUP_BITS-1:0]  group;
	logic                   more;
	logic [BYTE_W-1:0]      byte_d;
	logic                   last_d;
	logic                   emit;

	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			lane_mask[i] = item_q.len[i] != '0;
			cand[i]      = lane_mask[i] && (mask_phase_q || (LANE_IDX_W'(i) > lane_q));
		end
		has_next  = |cand;
		next_lane = '0;
		for (int i = NUM_LANES - 1; i >= 0; i--) begin
			if (cand[i]) begin
				next_lane = LANE_IDX_W'(i);
			end
		end
		padded = PAD_W'(item_q.code[lane_q]);
		group  = padded[byte_q * GROUP_BITS +: GROUP_BITS];
		more   = ({1'b0, byte_q} + (LEN_W + 1)'(1)) < {1'b0, item_q.len[lane_q]};
		if (mask_phase_q) begin
			byte_d = BYTE_W'(lane_mask);
			last_d = !has_next;
		end else begin
			byte_d = {more, group};
			last_d = !more && !has_next;
		end
	end

	assign emit      = busy_q && (!out_valid_q || !out_stall);
	assign item_take = item_valid && (!busy_q || (emit && last_d));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			mask_phase_q <= 1'b0;
			lane_q       <= '0;
			byte_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (item_take) begin
				busy_q       <= 1'b1;
				mask_phase_q <= 1'b1;
				lane_q       <= '0;
				byte_q       <= '0;
			end else if (emit) begin
				if (last_d) begin
					busy_q <= 1'b0;
				end else if (mask_phase_q || !more) begin
					mask_phase_q <= 1'b0;
					lane_q       <= next_lane;
					byte_q       <= '0;
				end else begin
					byte_q <= byte_q + LEN_W'(1);
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			item_q <= item;
		end
		if (emit) begin
			out_byte_q <= byte_d;
			last_q     <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

endmodule

/* src/input_delta_varint_encoder_core.sv */
`timescale 1ns / 1ps

// Delta encoder for per-player controller state.
// Input channel (in_valid / in_stall): one item per tick of one player, with
// four signed axes and a button word. The block compares it with the state
// stored for that player and updates that state at the accepting edge, so
// items for the same player may follow each other in consecutive cycles.
// Items whose player number is not below PLAYERS are taken and dropped.
// Output channel (out_valid / out_stall): one stream byte per handshake:
// the change mask, then a zigzag LEB128 varint per changed axis, then the
// XOR of old and new buttons as a varint if they changed; last marks the
// final byte of each item.
// The mask byte passes the stage register, the serializer's item register
// and its output register. Throughput: the serializer sends one byte per
// cycle while out_stall is low, 1 to 18 bytes per item (one mask byte plus
// its varint bytes), with no gap between items. A stage register in front
// of it lets the next item be accepted while the current one is sent.
// A stall on the output holds the byte in place; backpressure then reaches
// the input once the stage register is full.
// Reset clears all stored player states to zero and empties the pipeline.
module input_delta_varint_encoder_core
	import ivde_pkg::*;
#(
	parameter int PLAYERS = PLAYERS_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [PLAYER_W-1:0]        player,
	input  logic signed [AXIS_W-1:0]   move_x,
	input  logic signed [AXIS_W-1:0]   move_y,
	input  logic signed [AXIS_W-1:0]   aim_x,
	input  logic signed [AXIS_W-1:0]   aim_y,
	input  logic [BUTTON_W-1:0]        buttons,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [BYTE_W-1:0]          out_byte,
	output logic                       last
);

	localparam int IDX_W = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;

	logic signed [AXIS_W-1:0] prev_axis_q [PLAYERS][NUM_AXES];
	logic [BUTTON_W-1:0]      prev_btn_q  [PLAYERS];

	logic [IDX_W-1:0]         idx;
	logic                     in_range;
	logic                     accept;
	logic signed [AXIS_W-1:0] new_axis [NUM_AXES];
	logic [BUTTON_W-1:0]      btn_xor;
	ivde_item_t               item_d;

	logic                     s1_valid_s1;
	ivde_item_t               item_s1;
	logic                     item_take;

	assign idx      = IDX_W'(player);
	assign in_range = int'(player) < PLAYERS;
	assign accept   = in_valid && !in_stall;
	assign in_stall = s1_valid_s1 && !item_take;

	assign new_axis[0] = move_x;
	assign new_axis[1] = move_y;
	assign new_axis[2] = aim_x;
	assign new_axis[3] = aim_y;

	// One lane per axis; the button lane is a plain XOR.
	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		ivde_axis_lane u_lane (
			.old_value (prev_axis_q[idx][a]),
			.new_value (new_axis[a]),
			.code      (item_d.code[a]),
			.len       (item_d.len[a])
		);
	end

	assign btn_xor                  = prev_btn_q[idx] ^ buttons;
	assign item_d.code[BUTTON_LANE] = LANE_W'(btn_xor);
	assign item_d.len[BUTTON_LANE]  = varint_len(LANE_W'(btn_xor));

	// Player state table, written at the accepting edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PLAYERS; p++) begin
				for (int a = 0; a < NUM_AXES; a++) begin
					prev_axis_q[p][a] <= '0;
				end
				prev_btn_q[p] <= '0;
			end
		end else if (accept && in_range) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				prev_axis_q[idx][a] <= new_axis[a];
			end
			prev_btn_q[idx] <= buttons;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (accept) begin
			s1_valid_s1 <= in_range;
		end else if (item_take) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_range) begin
			item_s1 <= item_d;
		end
	end

	ivde_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (s1_valid_s1),
		.item       (item_s1),
		.item_take  (item_take),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.last       (last)
	);

	// The serializer only ever takes an item that is waiting in stage 1.
	a_take_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_take |-> s1_valid_s1)
		else $error("serializer took an item from an empty stage");

	// A varint byte that announces more bytes can never close an item, and the
	// mask byte never has its top bit set.
	a_cont_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_byte[BYTE_W-1] |-> !last)
		else $error("continuation byte flagged as last");

	// An accepted item for a known player is waiting in stage 1 in the next cycle.
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_range |=> s1_valid_s1)
		else $error("accepted item did not reach stage 1");

endmodule

/* tb/ivde_stream_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the delta encoder, predicts the byte stream for
// every accepted item and compares each accepted output byte with it.
module ivde_stream_checker
	import ivde_pkg::*;
#(
	parameter int PLAYERS = PLAYERS_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [PLAYER_W-1:0]      player,
	input  logic signed [AXIS_W-1:0] move_x,
	input  logic signed [AXIS_W-1:0] move_y,
	input  logic signed [AXIS_W-1:0] aim_x,
	input  logic signed [AXIS_W-1:0] aim_y,
	input  logic [BUTTON_W-1:0]      buttons,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic [BYTE_W-1:0]        out_byte,
	input  logic                     last,
	output int                       pending,
	output int                       mismatches
);

	localparam int MAX_ITEM_BYTES = 1 + NUM_AXES * 3 + MAX_GROUPS;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} stream_byte_t;

	stream_byte_t             expected_bytes[$];
	logic signed [AXIS_W-1:0] seen_axis [PLAYERS][NUM_AXES];
	logic [BUTTON_W-1:0]      seen_buttons [PLAYERS];

	// Appends the encoded stream of one item and updates that player's state.
	task automatic encode_delta_item(input logic [PLAYER_W-1:0] p,
			input logic [NUM_AXES-1:0][AXIS_W-1:0] axes,
			input logic [BUTTON_W-1:0] btn);
		logic [NUM_LANES-1:0]  changed;
		logic [LANE_W-1:0]     lane_val [NUM_LANES];
		logic [LANE_W-1:0]     rest;
		stream_byte_t          item_bytes [MAX_ITEM_BYTES];
		int                    diff;
		int                    n;
		if (int'(p) >= PLAYERS) begin
			return;
		end
		for (int i = 0; i < NUM_AXES; i++) begin
			changed[i] = ($signed(axes[i]) != seen_axis[p][i]);
			diff = int'($signed(axes[i])) - int'(seen_axis[p][i]);
			if (diff >= 0) begin
				lane_val[i] = LANE_W'(diff) << 1;
			end else begin
				lane_val[i] = (LANE_W'(-diff) << 1) - 1;
			end
		end
		changed[BUTTON_LANE] = (btn != seen_buttons[p]);
		lane_val[BUTTON_LANE] = seen_buttons[p] ^ btn;

		item_bytes[0] = '{data: BYTE_W'(changed), last: 1'b0};
		n = 1;
		for (int lane = 0; lane < NUM_LANES; lane++) begin
			if (changed[lane]) begin
				rest = lane_val[lane];
				do begin
					item_bytes[n].data = {1'b0, rest[GROUP_BITS-1:0]};
					rest = rest >> GROUP_BITS;
					item_bytes[n].data[BYTE_W-1] = (rest != '0);
					item_bytes[n].last = 1'b0;
					n++;
				end while (rest != '0);
			end
		end
		item_bytes[n-1].last = 1'b1;
		for (int i = 0; i < n; i++) begin
			expected_bytes.insert(expected_bytes.size(), item_bytes[i]);
		end

		for (int i = 0; i < NUM_AXES; i++) begin
			seen_axis[p][i] = $signed(axes[i]);
		end
		seen_buttons[p] = btn;
	endtask

	always @(posedge clk or negedge arst_n) begin
		stream_byte_t want;
		if (!arst_n) begin
			expected_bytes.delete();
			for (int p = 0; p < PLAYERS; p++) begin
				for (int i = 0; i < NUM_AXES; i++) begin
					seen_axis[p][i] = '0;
				end
				seen_buttons[p] = '0;
			end
			mismatches = 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					$error("out_byte: expected nothing, got %02h", out_byte);
					mismatches++;
				end else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want.data) begin
						$error("out_byte: expected %02h, got %02h", want.data, out_byte);
						mismatches++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, last);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				encode_delta_item(player, {aim_y, aim_x, move_y, move_x}, buttons);
			end
			pending <= expected_bytes.size();
		end
	end

endmodule

/* tb/input_delta_varint_encoder_core_test.sv */
`timescale 1ns / 1ps

// Top of the encoder test. It only makes stimulus and gives the verdict;
// prediction and comparison live in the stream checker beside the block.
module input_delta_varint_encoder_core_test;
	import ivde_pkg::*;

	// Far above the slowest correct run: about 150 items of up to 18 bytes,
	// each byte possibly stalled, plus gaps, pauses and the reset.
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 130;
	localparam int IDLE_PERCENT  = 22;
	localparam int SETTLE_CYCLES = 20;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [PLAYER_W-1:0]      player;
	logic signed [AXIS_W-1:0] move_x;
	logic signed [AXIS_W-1:0] move_y;
	logic signed [AXIS_W-1:0] aim_x;
	logic signed [AXIS_W-1:0] aim_y;
	logic [BUTTON_W-1:0]      buttons;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [BYTE_W-1:0]        out_byte;
	logic                     last;

	int pending;
	int mismatches;
	int cycles = 0;

	// While set, neither side idles; this gives one long back-to-back stretch.
	bit calm = 1'b0;

	// The values last sent per player. Random items reuse them so that many
	// axes stay unchanged or move only a little, which exercises the mask and
	// the short varints as well as the long ones.
	logic signed [AXIS_W-1:0] sent_axis [PLAYERS_DEFAULT][NUM_AXES];
	logic [BUTTON_W-1:0]      sent_buttons [PLAYERS_DEFAULT];

	input_delta_varint_encoder_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.player    (player),
		.move_x    (move_x),
		.move_y    (move_y),
		.aim_x     (aim_x),
		.aim_y     (aim_y),
		.buttons   (buttons),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

	ivde_stream_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.player     (player),
		.move_x     (move_x),
		.move_y     (move_y),
		.aim_x      (aim_x),
		.aim_y      (aim_y),
		.buttons    (buttons),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.last       (last),
		.pending    (pending),
		.mismatches (mismatches)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver stalls at random, except during the calm stretch.
	always @(posedge clk) begin
		out_stall <= arst_n && !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
	end

	// Watchdog: a hung handshake or a missing byte ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[input_delta_varint_encoder_core] ERROR");
			$finish;
		end
	end

	// Offers one item, after an optional random gap, and holds it until the
	// block takes it. When no gap is taken, in_valid simply stays high, so
	// back-to-back items never see valid dropped and raised in one step.
	task automatic send_item(input logic [PLAYER_W-1:0] p,
			input logic signed [AXIS_W-1:0] mx, input logic signed [AXIS_W-1:0] my,
			input logic signed [AXIS_W-1:0] ax, input logic signed [AXIS_W-1:0] ay,
			input logic [BUTTON_W-1:0] btn);
		while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		player   <= p;
		move_x   <= mx;
		move_y   <= my;
		aim_x    <= ax;
		aim_y    <= ay;
		buttons  <= btn;
		sent_axis[p][0] = mx;
		sent_axis[p][1] = my;
		sent_axis[p][2] = ax;
		sent_axis[p][3] = ay;
		sent_buttons[p] = btn;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
	endtask

	// Holds the sender off until every predicted byte has come out. The
	// checker's count is registered, so the task lets it update before trusting it.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	// Same value, a small step, or anything at all.
	function automatic logic signed [AXIS_W-1:0] next_axis(input logic signed [AXIS_W-1:0] prior);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			return prior;
		end else if (pick < 75) begin
			return prior + AXIS_W'(int'($urandom_range(0, 400)) - 200);
		end
		return AXIS_W'($urandom);
	endfunction

	// Same buttons, one button toggled, or a whole new set.
	function automatic logic [BUTTON_W-1:0] next_buttons(input logic [BUTTON_W-1:0] prior);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			return prior;
		end else if (pick < 70) begin
			return prior ^ (BUTTON_W'(1) << $urandom_range(0, BUTTON_W - 1));
		end
		return BUTTON_W'($urandom);
	endfunction

	initial begin
		logic [PLAYER_W-1:0] p;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		player   = '0;
		move_x   = '0;
		move_y   = '0;
		aim_x    = '0;
		aim_y    = '0;
		buttons  = '0;
		for (int i = 0; i < PLAYERS_DEFAULT; i++) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				sent_axis[i][a] = '0;
			end
			sent_buttons[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. An all-zero item against the reset state changes
		// nothing, so only the mask byte comes out.
		send_item(0, 0, 0, 0, 0, 32'h0000_0000);
		// Largest item: every axis to an extreme and every button set.
		send_item(0, 32767, -32768, 32767, -32768, 32'hFFFF_FFFF);
		// Full swing to the opposite extremes, the largest zigzag codes.
		send_item(0, -32768, 32767, -32768, 32767, 32'h0000_0000);
		// Repeating an item changes nothing.
		send_item(0, -32768, 32767, -32768, 32767, 32'h0000_0000);
		// Steps of one each way give the smallest zigzag codes.
		send_item(1, 1, 0, 0, 0, 32'h0000_0000);
		send_item(1, 0, 0, 0, 0, 32'h0000_0000);
		send_item(1, 0, -1, 0, 0, 32'h0000_0000);
		// Around the seven-bit group boundary.
		send_item(1, 0, -1, 63, 0, 32'h0000_0000);
		send_item(1, 0, -1, 127, 0, 32'h0000_0000);
		send_item(1, 0, -1, 127, -8192, 32'h0000_0000);
		send_item(2, 0, 0, 0, -8193, 32'h0000_0000);
		// Button deltas of one, two and five bytes.
		send_item(2, 0, 0, 0, -8193, 32'h0000_007F);
		send_item(2, 0, 0, 0, -8193, 32'h0000_00FF);
		send_item(2, 0, 0, 0, -8193, 32'h8000_00FF);
		// Highest player, then a change of buttons alone.
		send_item(7, 32767, 32767, 32767, 32767, 32'h5555_5555);
		send_item(7, 32767, 32767, 32767, 32767, 32'hAAAA_AAAA);
		send_item(3, -1, -1, -1, -1, 32'h0000_0001);
		send_item(4, 0, 0, 0, 0, 32'h0FFF_FFFF);
		send_item(5, -32768, 0, 0, 0, 32'h0000_0000);
		send_item(6, 0, 0, 0, 32767, 32'h0000_0000);
		send_item(0, 0, 0, 0, 0, 32'h0000_0000);

		// Let the whole directed stream drain before the random part.
		wait_drained();

		// Random part, with one calm stretch and one more full drain.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= 50 && n < 90);
			if (n == 110) begin
				wait_drained();
			end
			p = PLAYER_W'($urandom_range(0, PLAYERS_DEFAULT - 1));
			send_item(p, next_axis(sent_axis[p][0]), next_axis(sent_axis[p][1]),
				next_axis(sent_axis[p][2]), next_axis(sent_axis[p][3]),
				next_buttons(sent_buttons[p]));
		end
		calm = 1'b0;

		// Wait for the last bytes, then a little longer to catch extras.
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("[input_delta_varint_encoder_core] OK");
		end else begin
			$display("[input_delta_varint_encoder_core] ERROR");
		end
		$finish;
	end

endmodule
